FILE: rtl/pvas_pkg.sv
// Package with types and constants for the pump valve acknowledgement supervisor.
`timescale 1ns / 1ps
package pvas_pkg;

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_ACK    = 3'd1,
    MODE_BUTTON = 3'd2,
    MODE_START  = 3'd3,
    MODE_STOP   = 3'd4,
    MODE_VALVE  = 3'd5
  } mode_t;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_V1   = 3'd1;
  localparam logic [2:0] PH_SW2  = 3'd2;
  localparam logic [2:0] PH_V2   = 3'd3;
  localparam logic [2:0] PH_SW3  = 3'd4;
  localparam logic [2:0] PH_V3   = 3'd5;
  localparam logic [2:0] PH_DONE = 3'd6;

  localparam logic [2:0] REG_ACK_TIMEOUT   = 3'd0;
  localparam logic [2:0] REG_RETRY_LIMIT   = 3'd1;
  localparam logic [2:0] REG_HB_RUNNING    = 3'd2;
  localparam logic [2:0] REG_HB_IDLE       = 3'd3;
  localparam logic [2:0] REG_MANUAL_STEP   = 3'd4;
  localparam logic [2:0] REG_SWITCH_TMO    = 3'd5;
  localparam logic [2:0] REG_FORCE_LIMIT   = 3'd6;
  localparam logic [2:0] REG_FORCE_PERIOD  = 3'd7;

  localparam logic [6:0]  CODE_V1 = 7'd100;
  localparam logic [6:0]  CODE_V2 = 7'd10;
  localparam logic [6:0]  CODE_V3 = 7'd1;
  localparam logic [15:0] ACK_V1 = 16'd200;
  localparam logic [15:0] ACK_V2 = 16'd20;
  localparam logic [15:0] ACK_V3 = 16'd2;
  localparam logic [31:0] BUTTON_LOCKOUT = 32'd500;
  localparam logic [15:0] NO_ACK_YET = 16'd9999;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] ack_code;
    logic [1:0]  valve_choice;
  } in_item_t;

  typedef struct packed {
    logic        send_valid;
    logic [6:0]  send_code;
    logic        pump_on;
    logic [6:0]  command_code;
    logic [15:0] latest_ack;
    logic [2:0]  manual_phase;
    logic        awaiting_ack;
    logic        forcing_off;
    logic        stopped_by_retry_failure;
  } out_item_t;

  typedef struct packed {
    logic [15:0] ack_timeout_ticks;
    logic [3:0]  retry_limit;
    logic [19:0] heartbeat_running_ticks;
    logic [19:0] heartbeat_idle_ticks;
    logic [21:0] manual_step_ticks;
    logic [15:0] switch_timeout_ticks;
    logic [3:0]  force_off_limit;
    logic [15:0] force_off_period_ticks;
  } cfg_t;

  // Acknowledgement bits a command code expects; the code only takes the
  // values 0, 1, 10 and 100, and any other code is decoded digit by digit.
  function automatic logic [15:0] ack_bits_for(input logic [6:0] sig);
    logic [6:0] hund;
    logic [6:0] rest;
    logic [6:0] tens;
    logic [6:0] units;
    hund = (sig >= 7'd100) ? 7'd1 : 7'd0;
    rest = (sig >= 7'd100) ? sig - 7'd100 : sig;
    // Multiplying by 205 / 2048 gives the exact tens digit for 0 to 99.
    tens = 7'((15'(rest) * 15'd205) >> 11);
    units = rest - 7'(tens * 7'd10);
    ack_bits_for = ((hund != 7'd0) ? ACK_V1 : 16'd0) |
                   ((tens != 7'd0) ? ACK_V2 : 16'd0) |
                   ((units != 7'd0) ? ACK_V3 : 16'd0);
  endfunction

  function automatic logic ack_ok(input logic [6:0] sig, input logic [15:0] ack);
    logic [15:0] req;
    req = ack_bits_for(sig);
    if (sig == 7'd0) ack_ok = (ack == 16'd0);
    else ack_ok = ((ack & req) != 16'd0) && ((ack & ~req) == 16'd0);
  endfunction

endpackage

FILE: rtl/pvas_stream_if.sv
// Valid/ready channel interface carrying one payload type.
`timescale 1ns / 1ps
interface pvas_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/pvas_cfg_regs.sv
// Configuration register file of the supervisor.
`timescale 1ns / 1ps
module pvas_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [21:0]        cfg_data,
  output pvas_pkg::cfg_t     cfg
);
  import pvas_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ack_timeout_ticks       <= 16'd3000;
      cfg.retry_limit             <= 4'd5;
      cfg.heartbeat_running_ticks <= 20'd10000;
      cfg.heartbeat_idle_ticks    <= 20'd60000;
      cfg.manual_step_ticks       <= 22'd120000;
      cfg.switch_timeout_ticks    <= 16'd15000;
      cfg.force_off_limit         <= 4'd10;
      cfg.force_off_period_ticks  <= 16'd2000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACK_TIMEOUT:  cfg.ack_timeout_ticks       <= cfg_data[15:0];
        REG_RETRY_LIMIT:  cfg.retry_limit             <= cfg_data[3:0];
        REG_HB_RUNNING:   cfg.heartbeat_running_ticks <= cfg_data[19:0];
        REG_HB_IDLE:      cfg.heartbeat_idle_ticks    <= cfg_data[19:0];
        REG_MANUAL_STEP:  cfg.manual_step_ticks       <= cfg_data;
        REG_SWITCH_TMO:   cfg.switch_timeout_ticks    <= cfg_data[15:0];
        REG_FORCE_LIMIT:  cfg.force_off_limit         <= cfg_data[3:0];
        REG_FORCE_PERIOD: cfg.force_off_period_ticks  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end
endmodule

FILE: rtl/pump_valve_ack_supervisor_unit.sv
// Top level of the pump valve acknowledgement supervisor.
`timescale 1ns / 1ps
// Each accepted event (tick, acknowledgement, button, manual start, stop or
// valve on) yields exactly one result item. An event is registered on input,
// the whole supervisor update is done in the next cycle and the result lands
// in a two-entry output buffer. One event is taken every cycle unless input
// is held off because the buffer, with the event in flight, would fill.
// Configuration writes take effect at the next edge; the user must make them
// while no event is in flight, which the block itself does not enforce.
module pump_valve_ack_supervisor_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data,
  pvas_stream_if.sink   in_ch,
  pvas_stream_if.source out_ch
);
  import pvas_pkg::*;

  cfg_t cfg;
  pvas_cfg_regs u_cfg (.clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cfg);

  // Supervisor state.
  logic [31:0] now_ticks, sent_at, heartbeat_at, force_sent_at, phase_start, button_at;
  logic [6:0]  requested_code, sent_code;
  logic [15:0] seen_ack, running_ack;
  logic [3:0]  resend_count, force_count;
  logic [2:0]  phase;
  logic pump_running, ack_pending, retry_fail_flag, heartbeat_waiting, force_active, switch_sent;

  logic [31:0] now_ticks_next, sent_at_next, heartbeat_at_next, force_sent_at_next;
  logic [31:0] phase_start_next, button_at_next;
  logic [6:0]  requested_code_next, sent_code_next;
  logic [15:0] seen_ack_next, running_ack_next;
  logic [3:0]  resend_count_next, force_count_next;
  logic [2:0]  phase_next;
  logic pump_running_next, ack_pending_next, retry_fail_flag_next;
  logic heartbeat_waiting_next, force_active_next, switch_sent_next;

  // Input register and two-entry output buffer.
  logic     item_valid;
  in_item_t item;
  out_item_t buf0, buf1, result;
  logic [1:0] count;
  logic       push, pop;

  assign in_ch.ready = (count == 2'd0) || (count == 2'd1 && !item_valid) ||
                       (count == 2'd1 && pop) ||
                       (count == 2'd2 && pop && !item_valid);
  assign push = item_valid;
  assign pop = out_ch.valid && out_ch.ready;
  assign out_ch.valid = (count != 2'd0);
  assign out_ch.data = buf0;

  always_ff @(posedge clk) begin
    if (rst) item_valid <= 1'b0;
    else item_valid <= in_ch.valid && in_ch.ready;
    if (in_ch.valid && in_ch.ready) item <= in_ch.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
      if (pop) begin
        buf0 <= (count == 2'd2) ? buf1 : result;
        if (push && count == 2'd2) buf1 <= result;
      end else if (push) begin
        if (count == 2'd0) buf0 <= result;
        else buf1 <= result;
      end
    end
  end

  always_comb begin
    logic tx_valid;
    logic [6:0] tx_code;
    logic [31:0] el;
    logic [31:0] period;
    logic [6:0] code;
    logic [15:0] ack;
    now_ticks_next = now_ticks; sent_at_next = sent_at; heartbeat_at_next = heartbeat_at;
    force_sent_at_next = force_sent_at; phase_start_next = phase_start;
    button_at_next = button_at; requested_code_next = requested_code;
    sent_code_next = sent_code; seen_ack_next = seen_ack; running_ack_next = running_ack;
    resend_count_next = resend_count; force_count_next = force_count; phase_next = phase;
    pump_running_next = pump_running; ack_pending_next = ack_pending;
    retry_fail_flag_next = retry_fail_flag; heartbeat_waiting_next = heartbeat_waiting;
    force_active_next = force_active; switch_sent_next = switch_sent;
    tx_valid = 1'b0; tx_code = 7'd0; el = 32'd0; period = 32'd0; code = 7'd0;
    ack = item.ack_code;

    case (item.mode)
      MODE_TICK: begin
        now_ticks_next = now_ticks + 32'd1;
        // Manual sequence.
        if (phase == PH_DONE) begin
          phase_next = PH_IDLE;
        end else if (phase != PH_IDLE && !ack_pending && !force_active) begin
          el = now_ticks_next - phase_start;
          if (phase == PH_V1 || phase == PH_V2) begin
            if (el >= {10'd0, cfg.manual_step_ticks}) begin
              if (pump_running) begin
                pump_running_next = 1'b0; running_ack_next = 16'd0;
                heartbeat_at_next = now_ticks_next;
              end
              requested_code_next = 7'd0; switch_sent_next = 1'b0;
              phase_start_next = now_ticks_next;
              phase_next = (phase == PH_V1) ? PH_SW2 : PH_SW3;
              retry_fail_flag_next = 1'b0; sent_code_next = 7'd0; ack_pending_next = 1'b1;
              sent_at_next = now_ticks_next; resend_count_next = 4'd0;
              tx_valid = 1'b1; tx_code = 7'd0;
            end
          end else if (phase == PH_SW2 || phase == PH_SW3) begin
            if (!switch_sent && (seen_ack == 16'd0 ||
                el > {16'd0, cfg.switch_timeout_ticks})) begin
              code = (phase == PH_SW2) ? CODE_V2 : CODE_V3;
              switch_sent_next = 1'b1; phase_start_next = now_ticks_next;
              phase_next = (phase == PH_SW2) ? PH_V2 : PH_V3;
              requested_code_next = code;
              retry_fail_flag_next = 1'b0; sent_code_next = code; ack_pending_next = 1'b1;
              sent_at_next = now_ticks_next; resend_count_next = 4'd0;
              tx_valid = 1'b1; tx_code = code;
            end
          end else if (phase == PH_V3) begin
            if (el >= {10'd0, cfg.manual_step_ticks}) begin
              phase_next = PH_DONE;
              if (pump_running) begin
                pump_running_next = 1'b0; running_ack_next = 16'd0;
                heartbeat_at_next = now_ticks_next;
              end
              requested_code_next = 7'd0;
              retry_fail_flag_next = 1'b0; sent_code_next = 7'd0; ack_pending_next = 1'b1;
              sent_at_next = now_ticks_next; resend_count_next = 4'd0;
              tx_valid = 1'b1; tx_code = 7'd0;
            end
          end
        end
        // Retry.
        if (ack_pending_next &&
            (now_ticks_next - sent_at_next) >= {16'd0, cfg.ack_timeout_ticks}) begin
          if (resend_count_next >= cfg.retry_limit) begin
            ack_pending_next = 1'b0; heartbeat_waiting_next = 1'b0;
            if (pump_running_next) begin
              pump_running_next = 1'b0; running_ack_next = 16'd0;
              heartbeat_at_next = now_ticks_next; retry_fail_flag_next = 1'b1;
            end
          end else begin
            resend_count_next = resend_count_next + 4'd1;
            sent_at_next = now_ticks_next;
            tx_valid = 1'b1; tx_code = sent_code_next;
          end
        end
        // Force-off.
        if (force_active_next) begin
          if (seen_ack_next == 16'd0) begin
            force_active_next = 1'b0; force_count_next = 4'd0;
          end else if (force_count_next >= cfg.force_off_limit) begin
            force_active_next = 1'b0;
          end else if ((now_ticks_next - force_sent_at_next) >=
                       {16'd0, cfg.force_off_period_ticks}) begin
            force_sent_at_next = now_ticks_next;
            force_count_next = force_count_next + 4'd1;
            tx_valid = 1'b1; tx_code = 7'd0;
          end
        end
        // Heartbeat.
        if (!force_active_next && !ack_pending_next) begin
          period = pump_running_next ? {12'd0, cfg.heartbeat_running_ticks}
                                     : {12'd0, cfg.heartbeat_idle_ticks};
          if ((now_ticks_next - heartbeat_at_next) >= period) begin
            heartbeat_at_next = now_ticks_next; heartbeat_waiting_next = 1'b1;
            code = pump_running_next ? requested_code_next : 7'd0;
            retry_fail_flag_next = 1'b0; sent_code_next = code; ack_pending_next = 1'b1;
            sent_at_next = now_ticks_next; resend_count_next = 4'd0;
            tx_valid = 1'b1; tx_code = code;
          end
        end
      end
      MODE_ACK: begin
        seen_ack_next = ack; ack_pending_next = 1'b0;
        if (force_active) begin
          if (ack == 16'd0) begin
            force_active_next = 1'b0; force_count_next = 4'd0;
          end
        end else if (heartbeat_waiting) begin
          heartbeat_waiting_next = 1'b0;
          if (pump_running) begin
            if (!ack_ok(requested_code, ack)) begin
              pump_running_next = 1'b0; running_ack_next = 16'd0;
              heartbeat_at_next = now_ticks;
              code = requested_code;
              retry_fail_flag_next = 1'b0; sent_code_next = code; ack_pending_next = 1'b1;
              sent_at_next = now_ticks; resend_count_next = 4'd0;
              tx_valid = 1'b1; tx_code = code;
            end else begin
              running_ack_next = ack;
            end
          end else if (ack != 16'd0) begin
            force_active_next = 1'b1; force_count_next = 4'd0; force_sent_at_next = 32'd0;
          end
        end else if (pump_running && requested_code != 7'd0) begin
          if (ack == 16'd0) begin
            pump_running_next = 1'b0; running_ack_next = 16'd0;
            heartbeat_at_next = now_ticks;
          end else if ((running_ack & ~ack) != 16'd0) begin
            pump_running_next = 1'b0; running_ack_next = 16'd0;
            heartbeat_at_next = now_ticks;
            code = requested_code;
            retry_fail_flag_next = 1'b0; sent_code_next = code; ack_pending_next = 1'b1;
            sent_at_next = now_ticks; resend_count_next = 4'd0;
            tx_valid = 1'b1; tx_code = code;
          end else begin
            running_ack_next = ack;
          end
        end else if (requested_code != 7'd0) begin
          // Pump is idle; an acceptable ack starts it unless retry failed.
          if (ack_ok(requested_code, ack)) begin
            if (retry_fail_flag) begin
              retry_fail_flag_next = 1'b0;
            end else begin
              pump_running_next = 1'b1; running_ack_next = ack;
              heartbeat_at_next = now_ticks;
            end
          end else if (!(ack == 16'd0 && pump_running)) begin
            code = requested_code;
            retry_fail_flag_next = 1'b0; sent_code_next = code; ack_pending_next = 1'b1;
            sent_at_next = now_ticks; resend_count_next = 4'd0;
            tx_valid = 1'b1; tx_code = code;
          end
        end else if (ack != 16'd0) begin
          retry_fail_flag_next = 1'b0; sent_code_next = 7'd0; ack_pending_next = 1'b1;
          sent_at_next = now_ticks; resend_count_next = 4'd0;
          tx_valid = 1'b1; tx_code = 7'd0;
        end
      end
      MODE_BUTTON, MODE_START, MODE_STOP, MODE_VALVE: begin
        if ((item.mode == MODE_BUTTON && (now_ticks - button_at) > BUTTON_LOCKOUT) ||
            (item.mode == MODE_START && phase == PH_IDLE) || item.mode == MODE_STOP ||
            (item.mode == MODE_VALVE && item.valve_choice != 2'd3)) begin
          if (item.mode == MODE_BUTTON) button_at_next = now_ticks;
          if (pump_running) begin
            pump_running_next = 1'b0; running_ack_next = 16'd0;
            heartbeat_at_next = now_ticks;
          end
          if (item.mode == MODE_VALVE) begin
            code = (item.valve_choice == 2'd0) ? CODE_V1 :
                   (item.valve_choice == 2'd1) ? CODE_V2 : CODE_V3;
          end else if (item.mode == MODE_STOP || phase != PH_IDLE) begin
            code = 7'd0; phase_next = PH_IDLE;
          end else begin
            code = CODE_V1; phase_next = PH_V1; phase_start_next = now_ticks;
            switch_sent_next = 1'b0;
          end
          requested_code_next = code;
          retry_fail_flag_next = 1'b0; sent_code_next = code; ack_pending_next = 1'b1;
          sent_at_next = now_ticks; resend_count_next = 4'd0;
          tx_valid = 1'b1; tx_code = code;
        end
      end
      default: ;
    endcase

    result.send_valid = tx_valid;
    result.send_code = tx_code;
    result.pump_on = pump_running_next;
    result.command_code = requested_code_next;
    result.latest_ack = seen_ack_next;
    result.manual_phase = phase_next;
    result.awaiting_ack = ack_pending_next;
    result.forcing_off = force_active_next;
    result.stopped_by_retry_failure = retry_fail_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ticks <= '0; sent_at <= '0; heartbeat_at <= '0; force_sent_at <= '0;
      phase_start <= '0; button_at <= '0; requested_code <= '0; sent_code <= '0;
      seen_ack <= NO_ACK_YET; running_ack <= '0; resend_count <= '0; force_count <= '0;
      phase <= PH_IDLE; pump_running <= 1'b0; ack_pending <= 1'b0;
      retry_fail_flag <= 1'b0; heartbeat_waiting <= 1'b0; force_active <= 1'b0;
      switch_sent <= 1'b0;
    end else if (item_valid) begin
      now_ticks <= now_ticks_next; sent_at <= sent_at_next;
      heartbeat_at <= heartbeat_at_next; force_sent_at <= force_sent_at_next;
      phase_start <= phase_start_next; button_at <= button_at_next;
      requested_code <= requested_code_next; sent_code <= sent_code_next;
      seen_ack <= seen_ack_next; running_ack <= running_ack_next;
      resend_count <= resend_count_next; force_count <= force_count_next;
      phase <= phase_next; pump_running <= pump_running_next;
      ack_pending <= ack_pending_next; retry_fail_flag <= retry_fail_flag_next;
      heartbeat_waiting <= heartbeat_waiting_next; force_active <= force_active_next;
      switch_sent <= switch_sent_next;
    end
  end
endmodule

FILE: rtl/pvas_checker.sv
// Port-level checks for the supervisor, bound to the top level.
`timescale 1ns / 1ps
module pvas_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input pvas_pkg::out_item_t out_data
);
  import pvas_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_idle_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.send_valid |-> out_data.send_code == 7'd0)
    else $error("send code set without a send");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.manual_phase != 3'd7)
    else $error("manual phase out of range");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("accepted item produced no result");
endmodule

bind pump_valve_ack_supervisor_unit pvas_checker u_pvas_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
